// File: sv/fvnh_pkg.sv
// Shared constants and helpers for the fractal value-noise height pipeline.
`default_nettype none
package fvnh_pkg;
    localparam int HEIGHT_LIMIT = 128;
    localparam int LAYERS       = 3;
    localparam int OCTAVES      = 4;
    localparam int NOISE_UNITS  = LAYERS * OCTAVES;

    typedef logic [31:0] word_t;
    typedef logic [15:0] q16_t;
    typedef logic signed [37:0] pos_t;
    typedef logic [47:0] fpos_t;

    localparam word_t SCR_K1   = 32'h7feb352d;
    localparam word_t SCR_K2   = 32'h846ca68b;
    localparam word_t HASH_X   = 32'h1f123bb5;
    localparam word_t HASH_Z   = 32'h5f356495;
    localparam word_t HASH_S   = 32'h9e3779b9;
    localparam word_t OCT_STEP = 32'd101;
    localparam word_t SEED_RST = 32'd13371337;

    localparam logic [26:0] NUM_BASE  = 27'd10813440;  // 11 * 15 * 65536
    localparam logic [26:0] NUM_HALF  = 27'd491520;
    localparam logic [14:0] RECIP_15  = 15'd17477;     // ~2^18 / 15
    localparam logic [9:0]  H_MIN     = 10'd6;
    localparam logic [9:0]  H_MAX     = 10'(HEIGHT_LIMIT - 6);

    function automatic logic signed [14:0] layer_scale(input logic [1:0] l);
        logic signed [14:0] r;
        case (l)
            2'd0:    r = 15'sd2294;
            2'd1:    r = 15'sd5571;
            default: r = 15'sd11796;
        endcase
        return r;
    endfunction

    function automatic word_t layer_salt(input logic [1:0] l);
        word_t r;
        case (l)
            2'd0:    r = 32'h1a2b3c4d;
            2'd1:    r = 32'h77889911;
            default: r = 32'h00bada55;
        endcase
        return r;
    endfunction
endpackage
`default_nettype wire

// File: sv/fractal_value_noise_height.sv
// Top level: seed register, position multiply stage, noise units and mixer.
//  channel | ports                              | direction
//  request | s_valid s_ready s_grid_x s_grid_z  | in
//  result  | m_valid m_ready m_surface_height   | out
//  config  | cfg_wr_en cfg_wr_data              | in
// One request per cycle while the pipeline is not stalled; eight register stages.
// Depth is set by the hash chain: three 32-bit multiplies, then two blends.
// Synchronous active-low reset clears valids and restores the seed.
// Stalls freeze the whole pipeline; s_ready follows the output register.
`default_nettype none
module fractal_value_noise_height (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [23:0] s_grid_x,
    input  wire logic [23:0] s_grid_z,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [9:0]       m_surface_height,
    input  wire logic        cfg_wr_en,
    input  wire logic [31:0] cfg_wr_data
);
    import fvnh_pkg::*;

    localparam int DEPTH = 8;

    word_t seed_reg;
    logic [DEPTH-1:0] vld_reg;
    logic en;
    pos_t plx_reg [LAYERS];
    pos_t plz_reg [LAYERS];
    word_t st_reg [NOISE_UNITS];
    q16_t noise [NOISE_UNITS];

    assign en      = !vld_reg[DEPTH-1] || m_ready;
    assign s_ready = en;
    assign m_valid = vld_reg[DEPTH-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seed_reg <= SEED_RST;
            vld_reg  <= '0;
        end else begin
            if (cfg_wr_en) begin
                seed_reg <= cfg_wr_data;
            end
            if (en) begin
                vld_reg <= {vld_reg[DEPTH-2:0], s_valid};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int l = 0; l < LAYERS; l++) begin
                plx_reg[l] <= 38'($signed(s_grid_x) * layer_scale(2'(l)));
                plz_reg[l] <= 38'($signed(s_grid_z) * layer_scale(2'(l)));
                for (int o = 0; o < OCTAVES; o++) begin
                    st_reg[l*OCTAVES+o] <= ((seed_reg ^ layer_salt(2'(l)))
                                           + OCT_STEP * 32'(o)) * HASH_S;
                end
            end
        end
    end

    for (genvar l = 0; l < LAYERS; l++) begin : g_layer
        for (genvar o = 0; o < OCTAVES; o++) begin : g_oct
            fpos_t px, pz;
            assign px = fpos_t'({{10{plx_reg[l][37]}}, plx_reg[l]}) << o;
            assign pz = fpos_t'({{10{plz_reg[l][37]}}, plz_reg[l]}) << o;
            fvnh_octave u_oct (
                .aclk      (aclk),
                .en        (en),
                .px        (px),
                .pz        (pz),
                .seed_term (st_reg[l*OCTAVES+o]),
                .noise     (noise[l*OCTAVES+o])
            );
        end
    end

    fvnh_mix u_mix (
        .aclk   (aclk),
        .en     (en),
        .noise  (noise),
        .height (m_surface_height)
    );
endmodule
`default_nettype wire

// File: sv/fvnh_octave.sv
// One value-noise sample: lattice hash, smoothstep and bilinear blend, five stages.
`default_nettype none
module fvnh_octave (
    input  wire logic          aclk,
    input  wire logic          en,
    input  wire fvnh_pkg::fpos_t px,
    input  wire fvnh_pkg::fpos_t pz,
    input  wire fvnh_pkg::word_t seed_term,
    output fvnh_pkg::q16_t     noise
);
    import fvnh_pkg::*;

    // stage 2
    word_t hx_reg, hz_reg, st2_reg;
    q16_t  tx_reg, tz_reg, tx2_reg, tz2_reg;
    // stage 3
    word_t m1_reg [4];
    q16_t  sx3_reg, sz3_reg;
    // stage 4
    word_t m2_reg [4];
    q16_t  sx4_reg, sz4_reg;
    // stage 5
    q16_t  a_reg, b_reg, sz5_reg;
    // stage 6
    q16_t  n_reg;

    logic [31:0] tx2_full, tz2_full;
    word_t hx1, hz1;
    word_t v3 [4];
    word_t v4 [4];
    q16_t  lat [4];
    logic [33:0] spx, spz;
    logic [32:0] a_sum, b_sum, n_sum;

    always_comb begin
        tx2_full = px[15:0] * px[15:0];
        tz2_full = pz[15:0] * pz[15:0];
        hx1 = hx_reg + HASH_X;
        hz1 = hz_reg + HASH_Z;
        // corners: 0=(x0,z0) 1=(x1,z0) 2=(x0,z1) 3=(x1,z1)
        v3[0] = hx_reg ^ hz_reg ^ st2_reg;
        v3[1] = hx1    ^ hz_reg ^ st2_reg;
        v3[2] = hx_reg ^ hz1    ^ st2_reg;
        v3[3] = hx1    ^ hz1    ^ st2_reg;
        for (int i = 0; i < 4; i++) begin
            v3[i] = v3[i] ^ (v3[i] >> 16);
            v4[i] = m1_reg[i] ^ (m1_reg[i] >> 15);
            lat[i] = m2_reg[i][31:16] ^ 16'(m2_reg[i] >> 32);
        end
        spx = 34'(tx2_reg) * (34'd196608 - {17'd0, tx_reg, 1'b0});
        spz = 34'(tz2_reg) * (34'd196608 - {17'd0, tz_reg, 1'b0});
        a_sum = 33'(lat[0]) * (33'd65536 - 33'(sx4_reg)) + 33'(lat[1]) * 33'(sx4_reg);
        b_sum = 33'(lat[2]) * (33'd65536 - 33'(sx4_reg)) + 33'(lat[3]) * 33'(sx4_reg);
        n_sum = 33'(a_reg) * (33'd65536 - 33'(sz5_reg)) + 33'(b_reg) * 33'(sz5_reg);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            hx_reg  <= px[47:16] * HASH_X;
            hz_reg  <= pz[47:16] * HASH_Z;
            st2_reg <= seed_term;
            tx_reg  <= px[15:0];
            tz_reg  <= pz[15:0];
            tx2_reg <= tx2_full[31:16];
            tz2_reg <= tz2_full[31:16];
            for (int i = 0; i < 4; i++) begin
                m1_reg[i] <= v3[i] * SCR_K1;
                m2_reg[i] <= v4[i] * SCR_K2;
            end
            sx3_reg <= spx[31:16];
            sz3_reg <= spz[31:16];
            sx4_reg <= sx3_reg;
            sz4_reg <= sz3_reg;
            a_reg   <= a_sum[31:16];
            b_reg   <= b_sum[31:16];
            sz5_reg <= sz4_reg;
            n_reg   <= n_sum[31:16];
        end
    end

    assign noise = n_reg;
endmodule
`default_nettype wire

// File: sv/fvnh_mix.sv
// Octave/layer weighting, rounding divide by 15*2^16 and clamp; two stages.
`default_nettype none
module fvnh_mix (
    input  wire logic           aclk,
    input  wire logic           en,
    input  wire fvnh_pkg::q16_t noise [fvnh_pkg::NOISE_UNITS],
    output logic [9:0]          height
);
    import fvnh_pkg::*;

    logic [19:0] acc [LAYERS];
    logic [26:0] num_next;
    logic [26:0] num_reg;
    logic [26:0] rnd;
    logic [10:0] q;
    logic [25:0] qm;
    logic [9:0]  d;
    logic [9:0]  h_next;
    logic [9:0]  h_reg;

    always_comb begin
        for (int l = 0; l < LAYERS; l++) begin
            acc[l] = (20'(noise[l*OCTAVES]) << 3) + (20'(noise[l*OCTAVES+1]) << 2)
                   + (20'(noise[l*OCTAVES+2]) << 1) + 20'(noise[l*OCTAVES+3]);
        end
        num_next = NUM_BASE + 27'(acc[0]) * 27'd22 + 27'(acc[1]) * 27'd10
                 + 27'(acc[2]) * 27'd4;
        rnd = num_reg + NUM_HALF;
        q   = rnd[26:16];
        qm  = q * RECIP_15;
        d   = qm[25:18] + 10'd0;
        if (d < H_MIN)      h_next = H_MIN;
        else if (d > H_MAX) h_next = H_MAX;
        else                h_next = d;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            num_reg <= num_next;
            h_reg   <= h_next;
        end
    end

    assign height = h_reg;
endmodule
`default_nettype wire
